// ===== rtl/rcap_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcap_pkg
// Shared types, constants and the square root step for the rounded corner
// coverage and alpha premultiply pipeline.
// ----------------------------------------------------------------------------
package rcap_pkg;

  localparam int MAX_DIM_DEF = 4096;

  localparam int DIM_W   = 13;
  localparam int RAD_CW  = 12;
  localparam int POS_W   = 12;
  localparam int BYTE_W  = 8;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CORNER_RADIUS = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ALPHA    = 4'd3;

  localparam logic [DIM_W-1:0]  FRAME_WIDTH_RST   = 13'd256;
  localparam logic [DIM_W-1:0]  FRAME_HEIGHT_RST  = 13'd128;
  localparam logic [RAD_CW-1:0] CORNER_RADIUS_RST = 12'd12;
  localparam logic [BYTE_W-1:0] BASE_ALPHA_RST    = 8'd255;

  localparam int OFS_W  = 13;
  localparam int SQ_W   = 2 * OFS_W;
  localparam int SUM_W  = SQ_W + 1;
  localparam int RAD_W  = 42;
  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 2;
  localparam int SQRT_STEPS_PER_STAGE = 3;
  localparam int SQRT_STAGES = ROOT_W / SQRT_STEPS_PER_STAGE;
  localparam int COV_W  = 9;
  localparam logic [COV_W-1:0] COV_FULL = 9'd256;

  typedef struct packed {
    logic              corner;
    logic [BYTE_W-1:0] blue;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] red;
  } side_t;

  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_state_t;

  function automatic sqrt_state_t sqrt_step(sqrt_state_t s);
    logic [REM_W+1:0] acc;
    logic [REM_W+1:0] trial;
    sqrt_state_t      n;
    acc   = {s.rem, s.rad[RAD_W-1 -: 2]};
    trial = (REM_W+2)'({s.root, 2'b01});
    n.rad = {s.rad[RAD_W-3:0], 2'b00};
    if (acc >= trial) begin
      n.rem  = REM_W'(acc - trial);
      n.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      n.rem  = REM_W'(acc);
      n.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return n;
  endfunction

endpackage

// ===== rtl/rcap_isqrt_pipe.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcap_isqrt_pipe
// Pipelined integer square root, a few result bits per stage, with a side
// payload and valid bits that travel alongside the radicand.
// ----------------------------------------------------------------------------
module rcap_isqrt_pipe (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [rcap_pkg::RAD_W-1:0] in_rad,
  input  rcap_pkg::side_t           in_side,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [rcap_pkg::ROOT_W-1:0] out_root,
  output rcap_pkg::side_t           out_side
);

  localparam int NS = rcap_pkg::SQRT_STAGES;

  rcap_pkg::sqrt_state_t st_r [NS];
  rcap_pkg::side_t       side_r [NS];
  logic [NS-1:0]         v_r;
  logic [NS:0]           rdy;

  assign rdy[NS] = out_ready;

  genvar i;
  generate
    for (i = 0; i < NS; i++) begin : g_stage
      rcap_pkg::sqrt_state_t st_in;
      rcap_pkg::sqrt_state_t st_nxt;
      rcap_pkg::side_t       side_in;
      logic                  v_in;

      assign rdy[i] = !v_r[i] || rdy[i+1];

      if (i == 0) begin : g_first
        assign st_in.rad  = in_rad;
        assign st_in.rem  = '0;
        assign st_in.root = '0;
        assign side_in    = in_side;
        assign v_in       = in_valid;
      end else begin : g_next
        assign st_in   = st_r[i-1];
        assign side_in = side_r[i-1];
        assign v_in    = v_r[i-1];
      end

      always_comb begin
        st_nxt = st_in;
        for (int k = 0; k < rcap_pkg::SQRT_STEPS_PER_STAGE; k++) begin
          st_nxt = rcap_pkg::sqrt_step(st_nxt);
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[i] <= 1'b0;
        end else if (rdy[i]) begin
          v_r[i] <= v_in;
        end
      end

      always_ff @(posedge clk) begin
        if (rdy[i]) begin
          st_r[i]   <= st_nxt;
          side_r[i] <= side_in;
        end
      end
    end
  endgenerate

  assign in_ready  = rdy[0];
  assign out_valid = v_r[NS-1];
  assign out_root  = st_r[NS-1].root;
  assign out_side  = side_r[NS-1];

endmodule

// ===== rtl/rounded_corner_alpha_premultiply_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rounded_corner_alpha_premultiply_top
// Per pixel rounded rectangle coverage, alpha from coverage and base alpha,
// and premultiplied BGRA output.
// ----------------------------------------------------------------------------
// Channel  Handshake              Beat contents
// in       in_valid / in_ready    x, y position and blue, green, red bytes
// out      out_valid / out_ready  premultiplied blue, green, red and alpha
// cfg      cfg_valid / cfg_ready  register index and write data
//
// One pixel can be accepted every cycle while the output is not stalled. There are
// fifteen register stages: four ahead of the seven stage square root (three bits
// per stage) and four behind. Reset is synchronous and active low; it empties
// the pipeline and restores the register defaults. Every stage holds its beat
// while the next is full and stalled; empty stages fill behind a stalled output,
// so nothing is lost.
// ----------------------------------------------------------------------------
module rounded_corner_alpha_premultiply_top #(
  parameter int MAX_DIM = rcap_pkg::MAX_DIM_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [rcap_pkg::POS_W-1:0]        in_x_pos,
  input  logic [rcap_pkg::POS_W-1:0]        in_y_pos,
  input  logic [rcap_pkg::BYTE_W-1:0]       in_blue_in,
  input  logic [rcap_pkg::BYTE_W-1:0]       in_green_in,
  input  logic [rcap_pkg::BYTE_W-1:0]       in_red_in,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [rcap_pkg::BYTE_W-1:0]       out_blue_out,
  output logic [rcap_pkg::BYTE_W-1:0]       out_green_out,
  output logic [rcap_pkg::BYTE_W-1:0]       out_red_out,
  output logic [rcap_pkg::BYTE_W-1:0]       out_alpha_out,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rcap_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rcap_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int DW = rcap_pkg::DIM_W;
  localparam int RW = rcap_pkg::RAD_CW;
  localparam int PW = rcap_pkg::POS_W;
  localparam int BW = rcap_pkg::BYTE_W;
  localparam int OW = rcap_pkg::OFS_W;

  // Configuration registers.
  logic [DW-1:0] frame_width_r, frame_height_r;
  logic [RW-1:0] corner_radius_r;
  logic [BW-1:0] base_alpha_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r   <= rcap_pkg::FRAME_WIDTH_RST;
      frame_height_r  <= rcap_pkg::FRAME_HEIGHT_RST;
      corner_radius_r <= rcap_pkg::CORNER_RADIUS_RST;
      base_alpha_r    <= rcap_pkg::BASE_ALPHA_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rcap_pkg::CFG_FRAME_WIDTH:   frame_width_r   <= cfg_data;
        rcap_pkg::CFG_FRAME_HEIGHT:  frame_height_r  <= cfg_data;
        rcap_pkg::CFG_CORNER_RADIUS: corner_radius_r <= cfg_data[RW-1:0];
        rcap_pkg::CFG_BASE_ALPHA:    base_alpha_r    <= cfg_data[BW-1:0];
        default: ;
      endcase
    end
  end

  // Values derived from the configuration, refreshed every cycle.
  logic [DW-1:0] w_sat_nxt, h_sat_nxt;
  logic [RW-1:0] half_w_nxt, half_h_nxt, r_eff_nxt;
  logic [RW-1:0] r_eff_r;
  logic [DW-1:0] w_sub_r_r, h_sub_r_r;
  logic          r_nz_r;

  always_comb begin
    w_sat_nxt  = (int'(frame_width_r) > MAX_DIM) ? DW'(MAX_DIM) : frame_width_r;
    h_sat_nxt  = (int'(frame_height_r) > MAX_DIM) ? DW'(MAX_DIM) : frame_height_r;
    half_w_nxt = w_sat_nxt[DW-1:1];
    half_h_nxt = h_sat_nxt[DW-1:1];
    r_eff_nxt  = corner_radius_r;
    if (r_eff_nxt > half_w_nxt) begin
      r_eff_nxt = half_w_nxt;
    end
    if (r_eff_nxt > half_h_nxt) begin
      r_eff_nxt = half_h_nxt;
    end
  end

  always_ff @(posedge clk) begin
    r_eff_r   <= r_eff_nxt;
    w_sub_r_r <= w_sat_nxt - DW'(r_eff_nxt);
    h_sub_r_r <= h_sat_nxt - DW'(r_eff_nxt);
    r_nz_r    <= (r_eff_nxt != '0);
  end

  // Ready chain: a stage loads when it is empty or the next one loads.
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, v8_r;
  logic en1, en2, en3, en4, en5, en6, en7, en8;
  logic sq_in_ready, sq_out_valid;

  assign en8 = !v8_r || out_ready;
  assign en7 = !v7_r || en8;
  assign en6 = !v6_r || en7;
  assign en5 = !v5_r || en6;
  assign en4 = !v4_r || sq_in_ready;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
      v8_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= sq_out_valid;
      if (en6) v6_r <= v5_r;
      if (en7) v7_r <= v6_r;
      if (en8) v8_r <= v7_r;
    end
  end

  // Stage 1: input capture.
  logic [PW-1:0]   x1_r, y1_r;
  rcap_pkg::side_t side1_r;

  always_ff @(posedge clk) begin
    if (en1) begin
      x1_r          <= in_x_pos;
      y1_r          <= in_y_pos;
      side1_r.corner <= 1'b0;
      side1_r.blue   <= in_blue_in;
      side1_r.green  <= in_green_in;
      side1_r.red    <= in_red_in;
    end
  end

  // Stage 2: corner test and absolute half-pixel offsets.
  logic          x_near, x_far, y_near, y_far;
  logic [RW-1:0] rx_nxt, ry_nxt;
  logic [DW-1:0] hx_nxt, hy_nxt;
  logic [OW-1:0] adx_nxt, ady_nxt;
  logic [OW-1:0] adx2_r, ady2_r;
  rcap_pkg::side_t side2_nxt;
  rcap_pkg::side_t side2_r;

  always_comb begin
    x_near = (x1_r < r_eff_r);
    x_far  = ({1'b0, x1_r} >= w_sub_r_r);
    y_near = (y1_r < r_eff_r);
    y_far  = ({1'b0, y1_r} >= h_sub_r_r);
    rx_nxt = r_eff_r - x1_r;
    ry_nxt = r_eff_r - y1_r;
    hx_nxt = {1'b0, x1_r} - w_sub_r_r;
    hy_nxt = {1'b0, y1_r} - h_sub_r_r;
    adx_nxt = x_near ? (OW'({rx_nxt, 1'b0}) - OW'(1)) : {hx_nxt[PW-1:0], 1'b1};
    ady_nxt = y_near ? (OW'({ry_nxt, 1'b0}) - OW'(1)) : {hy_nxt[PW-1:0], 1'b1};
    side2_nxt        = side1_r;
    side2_nxt.corner = r_nz_r && (x_near || x_far) && (y_near || y_far);
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      adx2_r  <= adx_nxt;
      ady2_r  <= ady_nxt;
      side2_r <= side2_nxt;
    end
  end

  // Stage 3: squares.
  logic [rcap_pkg::SQ_W-1:0] sqx3_r, sqy3_r;
  rcap_pkg::side_t side3_r;

  always_ff @(posedge clk) begin
    if (en3) begin
      sqx3_r  <= adx2_r * adx2_r;
      sqy3_r  <= ady2_r * ady2_r;
      side3_r <= side2_r;
    end
  end

  // Stage 4: sum of squares, scaled so the root comes out in 1/256 pixel.
  logic [rcap_pkg::SUM_W-1:0] sum4_r;
  rcap_pkg::side_t side4_r;

  always_ff @(posedge clk) begin
    if (en4) begin
      sum4_r  <= rcap_pkg::SUM_W'(sqx3_r) + rcap_pkg::SUM_W'(sqy3_r);
      side4_r <= side3_r;
    end
  end

  logic [rcap_pkg::RAD_W-1:0]  sq_rad;
  logic [rcap_pkg::ROOT_W-1:0] sq_root;
  rcap_pkg::side_t             sq_side;

  assign sq_rad = rcap_pkg::RAD_W'({sum4_r, 14'd0});

  rcap_isqrt_pipe u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v4_r),
    .in_ready  (sq_in_ready),
    .in_rad    (sq_rad),
    .in_side   (side4_r),
    .out_valid (sq_out_valid),
    .out_ready (en5),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  // Stage 5: coverage in 1/256 steps.
  logic [RW+7:0]               edge_pos;
  logic [rcap_pkg::ROOT_W-1:0] edge_ext;
  logic [rcap_pkg::ROOT_W-1:0] diff_nxt;
  logic [rcap_pkg::COV_W-1:0]  cov_nxt, cov5_r;
  rcap_pkg::side_t             side5_r;

  always_comb begin
    edge_pos = {r_eff_r, 8'd128};
    edge_ext = rcap_pkg::ROOT_W'(edge_pos);
    diff_nxt = edge_ext - sq_root;
    if (!sq_side.corner) begin
      cov_nxt = rcap_pkg::COV_FULL;
    end else if (sq_root >= edge_ext) begin
      cov_nxt = '0;
    end else if (diff_nxt > rcap_pkg::ROOT_W'(rcap_pkg::COV_FULL)) begin
      cov_nxt = rcap_pkg::COV_FULL;
    end else begin
      cov_nxt = diff_nxt[rcap_pkg::COV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      cov5_r  <= cov_nxt;
      side5_r <= sq_side;
    end
  end

  // Stage 6: alpha, rounded.
  logic [15:0]     alpha_sum;
  logic [BW-1:0]   alpha6_r;
  rcap_pkg::side_t side6_r;

  assign alpha_sum = 16'(cov5_r) * 16'(base_alpha_r) + 16'd128;

  always_ff @(posedge clk) begin
    if (en6) begin
      alpha6_r <= alpha_sum[15:8];
      side6_r  <= side5_r;
    end
  end

  // Stage 7: color times alpha.
  logic [2*BW-1:0] pb7_r, pg7_r, pr7_r;
  logic [BW-1:0]   alpha7_r;

  always_ff @(posedge clk) begin
    if (en7) begin
      pb7_r    <= side6_r.blue * alpha6_r;
      pg7_r    <= side6_r.green * alpha6_r;
      pr7_r    <= side6_r.red * alpha6_r;
      alpha7_r <= alpha6_r;
    end
  end

  // Stage 8: exact floor of a 16-bit product over 255, into the output register.
  function automatic logic [BW-1:0] div255(logic [2*BW-1:0] p);
    logic [2*BW:0] t;
    t = {1'b0, p} + (2*BW+1)'(p[2*BW-1:BW]) + (2*BW+1)'(1);
    return t[2*BW-1:BW];
  endfunction

  logic [BW-1:0] ob8_r, og8_r, or8_r, oa8_r;

  always_ff @(posedge clk) begin
    if (en8) begin
      ob8_r <= div255(pb7_r);
      og8_r <= div255(pg7_r);
      or8_r <= div255(pr7_r);
      oa8_r <= alpha7_r;
    end
  end

  assign out_valid     = v8_r;
  assign out_blue_out  = ob8_r;
  assign out_green_out = og8_r;
  assign out_red_out   = or8_r;
  assign out_alpha_out = oa8_r;

  // A free output slot always reaches the input through the ready chain.
  a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input not ready while the output can advance");

  // Premultiplied colors never exceed alpha.
  a_premult_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_blue_out <= out_alpha_out && out_green_out <= out_alpha_out
                   && out_red_out <= out_alpha_out))
    else $error("premultiplied color above alpha");

  // The clamped radius never exceeds half the frame width.
  a_radius_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (DW'(r_eff_r) <= w_sub_r_r))
    else $error("effective radius above half the frame width");

endmodule

// ===== verif/rcap_bgra_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcap_bgra_checker
// Watches the pixel, result and register channels of the rounded corner
// block. It keeps its own copy of the registers, predicts the premultiplied
// BGRA beat for every accepted pixel and compares each result beat, field by
// field, with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module rcap_bgra_checker #(
  parameter int MAX_DIM = rcap_pkg::MAX_DIM_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [rcap_pkg::POS_W-1:0]      in_x_pos,
  input  logic [rcap_pkg::POS_W-1:0]      in_y_pos,
  input  logic [rcap_pkg::BYTE_W-1:0]     in_blue_in,
  input  logic [rcap_pkg::BYTE_W-1:0]     in_green_in,
  input  logic [rcap_pkg::BYTE_W-1:0]     in_red_in,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [rcap_pkg::BYTE_W-1:0]     out_blue_out,
  input  logic [rcap_pkg::BYTE_W-1:0]     out_green_out,
  input  logic [rcap_pkg::BYTE_W-1:0]     out_red_out,
  input  logic [rcap_pkg::BYTE_W-1:0]     out_alpha_out,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [rcap_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rcap_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              fail_count,
  output int                              outstanding,
  output int                              results_checked
);

  typedef struct packed {
    logic [rcap_pkg::BYTE_W-1:0] blue;
    logic [rcap_pkg::BYTE_W-1:0] green;
    logic [rcap_pkg::BYTE_W-1:0] red;
    logic [rcap_pkg::BYTE_W-1:0] alpha;
  } bgra_t;

  bgra_t                        pending_bgra[$];
  logic [rcap_pkg::DIM_W-1:0]   width_q  = rcap_pkg::FRAME_WIDTH_RST;
  logic [rcap_pkg::DIM_W-1:0]   height_q = rcap_pkg::FRAME_HEIGHT_RST;
  logic [rcap_pkg::RAD_CW-1:0]  radius_q = rcap_pkg::CORNER_RADIUS_RST;
  logic [rcap_pkg::BYTE_W-1:0]  base_q   = rcap_pkg::BASE_ALPHA_RST;

  initial begin
    fail_count      = 0;
    outstanding     = 0;
    results_checked = 0;
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root;
    longint unsigned probe;
    root = 0;
    for (int k = 22; k >= 0; k--) begin
      probe = root | (64'd1 << k);
      if (probe * probe <= v) root = probe;
    end
    return root;
  endfunction

  // Coverage in 1/256 steps: full outside the corner squares, otherwise
  // radius plus one half minus the distance to the corner center.
  function automatic int unsigned coverage_q8(int unsigned px, int unsigned py);
    int unsigned     w;
    int unsigned     h;
    int unsigned     r;
    int unsigned     cx;
    int unsigned     cy;
    longint          ox;
    longint          oy;
    longint          cov;
    longint unsigned dist_q8;
    w = (width_q > MAX_DIM) ? MAX_DIM : width_q;
    h = (height_q > MAX_DIM) ? MAX_DIM : height_q;
    r = radius_q;
    if (r > w / 2) r = w / 2;
    if (r > h / 2) r = h / 2;
    if (r == 0) return rcap_pkg::COV_FULL;
    if (px < r) cx = r;
    else if (px >= w - r) cx = w - r;
    else return rcap_pkg::COV_FULL;
    if (py < r) cy = r;
    else if (py >= h - r) cy = h - r;
    else return rcap_pkg::COV_FULL;
    ox = 2 * longint'(px) + 1 - 2 * longint'(cx);
    oy = 2 * longint'(py) + 1 - 2 * longint'(cy);
    dist_q8 = int_sqrt(64'(ox * ox + oy * oy) * 64'd16384);
    cov = longint'(r) * 256 + 128 - longint'(dist_q8);
    if (cov < 0) cov = 0;
    if (cov > rcap_pkg::COV_FULL) cov = rcap_pkg::COV_FULL;
    return 32'(cov);
  endfunction

  function automatic bgra_t premultiply_pixel(logic [rcap_pkg::POS_W-1:0] x,
                                              logic [rcap_pkg::POS_W-1:0] y,
                                              logic [rcap_pkg::BYTE_W-1:0] b,
                                              logic [rcap_pkg::BYTE_W-1:0] g,
                                              logic [rcap_pkg::BYTE_W-1:0] r);
    int unsigned cov;
    int unsigned a;
    bgra_t       p;
    cov = coverage_q8(x, y);
    a = (cov * base_q + 128) >> 8;
    if (a > 255) a = 255;
    p.blue  = 8'(b * a / 255);
    p.green = 8'(g * a / 255);
    p.red   = 8'(r * a / 255);
    p.alpha = 8'(a);
    return p;
  endfunction

  task automatic check_byte(string field, logic [rcap_pkg::BYTE_W-1:0] want,
                            logic [rcap_pkg::BYTE_W-1:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    bgra_t want;
    if (!rst_n) begin
      pending_bgra.delete();
      width_q  = rcap_pkg::FRAME_WIDTH_RST;
      height_q = rcap_pkg::FRAME_HEIGHT_RST;
      radius_q = rcap_pkg::CORNER_RADIUS_RST;
      base_q   = rcap_pkg::BASE_ALPHA_RST;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          rcap_pkg::CFG_FRAME_WIDTH:   width_q  = cfg_data;
          rcap_pkg::CFG_FRAME_HEIGHT:  height_q = cfg_data;
          rcap_pkg::CFG_CORNER_RADIUS: radius_q = cfg_data[rcap_pkg::RAD_CW-1:0];
          rcap_pkg::CFG_BASE_ALPHA:    base_q   = cfg_data[rcap_pkg::BYTE_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (pending_bgra.size() == 0) begin
          fail_count++;
          $display("%0t: result beat with nothing expected, got B %0d G %0d R %0d A %0d",
                   $time, out_blue_out, out_green_out, out_red_out, out_alpha_out);
        end else begin
          want = pending_bgra.pop_front();
          check_byte("blue", want.blue, out_blue_out);
          check_byte("green", want.green, out_green_out);
          check_byte("red", want.red, out_red_out);
          check_byte("alpha", want.alpha, out_alpha_out);
          results_checked++;
        end
      end
      if (in_valid && in_ready) begin
        pending_bgra.push_back(premultiply_pixel(in_x_pos, in_y_pos, in_blue_in,
                                                 in_green_in, in_red_in));
      end
    end
    outstanding <= pending_bgra.size();
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the rounded corner coverage and alpha premultiply block. A
// short directed set of pixels runs at the reset settings, then a series of
// register settings, extreme and random, each followed by pixels aimed mostly
// at the corner squares. Both channels pace themselves at random, and the
// result side stalls for a long stretch twice so that the pipeline backs up.
// ----------------------------------------------------------------------------
module tb;

  localparam int CLK_PERIOD        = 20;
  localparam int RESET_CYCLES      = 10;
  localparam int ITEMS_PER_SETTING = 75;
  localparam int SETTING_COUNT     = 16;
  localparam int HOLD_CYCLES       = 500;
  localparam int TAIL_CYCLES       = 30;
  localparam int CYCLE_LIMIT       = 400000;
  localparam int POS_MAX           = (1 << rcap_pkg::POS_W) - 1;
  localparam int CFG_IDX_MAX       = (1 << rcap_pkg::CFG_IDX_W) - 1;

  typedef enum int {PACE_BURST, PACE_UNIFORM, PACE_SPARSE} pace_t;

  typedef struct {
    int unsigned width;
    int unsigned height;
    int unsigned radius;
    int unsigned alpha;
  } setting_t;

  logic                            clk       = 1'b0;
  logic                            rst_n     = 1'b0;
  logic                            in_valid  = 1'b0;
  logic [rcap_pkg::POS_W-1:0]      in_x_pos  = '0;
  logic [rcap_pkg::POS_W-1:0]      in_y_pos  = '0;
  logic [rcap_pkg::BYTE_W-1:0]     in_blue_in  = '0;
  logic [rcap_pkg::BYTE_W-1:0]     in_green_in = '0;
  logic [rcap_pkg::BYTE_W-1:0]     in_red_in   = '0;
  logic                            out_ready = 1'b0;
  logic                            cfg_valid = 1'b0;
  logic [rcap_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [rcap_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
  logic                            in_ready;
  logic                            out_valid;
  logic                            cfg_ready;
  logic [rcap_pkg::BYTE_W-1:0]     out_blue_out;
  logic [rcap_pkg::BYTE_W-1:0]     out_green_out;
  logic [rcap_pkg::BYTE_W-1:0]     out_red_out;
  logic [rcap_pkg::BYTE_W-1:0]     out_alpha_out;

  int          fail_count;
  int          outstanding;
  int          results_checked;
  int          cycle_count = 0;
  int          backpressure_cycles = 0;
  int          settings_applied = 0;
  int          pixels_sent = 0;
  int          hold_req = 0;
  logic        hold_active = 1'b0;
  pace_t       send_pace = PACE_UNIFORM;
  int unsigned span_w = rcap_pkg::FRAME_WIDTH_RST;
  int unsigned span_h = rcap_pkg::FRAME_HEIGHT_RST;
  int unsigned eff_radius = rcap_pkg::CORNER_RADIUS_RST;

  rounded_corner_alpha_premultiply_top #(.MAX_DIM(rcap_pkg::MAX_DIM_DEF)) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_x_pos      (in_x_pos),
    .in_y_pos      (in_y_pos),
    .in_blue_in    (in_blue_in),
    .in_green_in   (in_green_in),
    .in_red_in     (in_red_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_blue_out  (out_blue_out),
    .out_green_out (out_green_out),
    .out_red_out   (out_red_out),
    .out_alpha_out (out_alpha_out),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  rcap_bgra_checker #(.MAX_DIM(rcap_pkg::MAX_DIM_DEF)) u_bgra_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_x_pos        (in_x_pos),
    .in_y_pos        (in_y_pos),
    .in_blue_in      (in_blue_in),
    .in_green_in     (in_green_in),
    .in_red_in       (in_red_in),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_blue_out    (out_blue_out),
    .out_green_out   (out_green_out),
    .out_red_out     (out_red_out),
    .out_alpha_out   (out_alpha_out),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .outstanding     (outstanding),
    .results_checked (results_checked)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  function automatic int unsigned draw_wait(pace_t pace);
    case (pace)
      PACE_BURST:   return 0;
      PACE_UNIFORM: return $urandom_range(0, 18);
      default:      return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 18) : 0;
    endcase
  endfunction

  // Most coordinates land in or near a corner square on either side.
  function automatic logic [rcap_pkg::POS_W-1:0] pick_coord(int unsigned span,
                                                            int unsigned rad);
    int unsigned top_pos;
    int unsigned far_start;
    int unsigned roll;
    int unsigned v;
    top_pos   = (span > POS_MAX + 1) ? POS_MAX : span - 1;
    far_start = (span > rad + 2) ? span - rad - 2 : 0;
    roll      = $urandom_range(0, 19);
    if (roll < 8) v = $urandom_range(0, rad + 1);
    else if (roll < 16) v = $urandom_range(far_start, top_pos);
    else if (roll < 19) v = $urandom_range(0, top_pos);
    else v = $urandom_range(0, POS_MAX);
    if (v > POS_MAX) v = POS_MAX;
    return rcap_pkg::POS_W'(v);
  endfunction

  function automatic logic [rcap_pkg::BYTE_W-1:0] pick_byte();
    int unsigned roll;
    roll = $urandom_range(0, 7);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return rcap_pkg::BYTE_W'($urandom_range(0, 255));
  endfunction

  task automatic send_pixel(input logic [rcap_pkg::POS_W-1:0] x,
                            input logic [rcap_pkg::POS_W-1:0] y,
                            input logic [rcap_pkg::BYTE_W-1:0] b,
                            input logic [rcap_pkg::BYTE_W-1:0] g,
                            input logic [rcap_pkg::BYTE_W-1:0] r);
    int unsigned gap;
    gap = hold_active ? 0 : draw_wait(send_pace);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_x_pos    <= x;
    in_y_pos    <= y;
    in_blue_in  <= b;
    in_green_in <= g;
    in_red_in   <= r;
    do @(posedge clk); while (!in_ready);
    pixels_sent++;
    if (pixels_sent % 40 == 0) send_pace = pace_t'($urandom_range(0, 2));
  endtask

  task automatic write_reg(input logic [rcap_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rcap_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic apply_setting(input setting_t s);
    int unsigned w;
    int unsigned h;
    write_reg(rcap_pkg::CFG_FRAME_WIDTH, rcap_pkg::CFG_DATA_W'(s.width));
    write_reg(rcap_pkg::CFG_FRAME_HEIGHT, rcap_pkg::CFG_DATA_W'(s.height));
    write_reg(rcap_pkg::CFG_CORNER_RADIUS, rcap_pkg::CFG_DATA_W'(s.radius));
    write_reg(rcap_pkg::CFG_BASE_ALPHA, rcap_pkg::CFG_DATA_W'(s.alpha));
    // An index past the last register must leave every register unchanged.
    write_reg(rcap_pkg::CFG_IDX_W'($urandom_range(rcap_pkg::CFG_BASE_ALPHA + 1,
                                                  CFG_IDX_MAX)),
              rcap_pkg::CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
    w = (s.width > rcap_pkg::MAX_DIM_DEF) ? rcap_pkg::MAX_DIM_DEF : s.width;
    h = (s.height > rcap_pkg::MAX_DIM_DEF) ? rcap_pkg::MAX_DIM_DEF : s.height;
    eff_radius = s.radius & ((1 << rcap_pkg::RAD_CW) - 1);
    if (eff_radius > w / 2) eff_radius = w / 2;
    if (eff_radius > h / 2) eff_radius = h / 2;
    span_w = (w == 0) ? 64 : w;
    span_h = (h == 0) ? 64 : h;
    settings_applied++;
  endtask

  task automatic drain();
    do @(posedge clk); while (outstanding != 0);
  endtask

  initial begin : timeout_watch
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_ready) backpressure_cycles <= backpressure_cycles + 1;
  end

  initial begin : result_sink
    pace_t       pace;
    int unsigned stall;
    int unsigned taken;
    int          last_hold;
    pace      = PACE_UNIFORM;
    taken     = 0;
    last_hold = 0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      stall = draw_wait(pace);
      if (hold_req != last_hold) begin
        last_hold = hold_req;
        stall = stall + HOLD_CYCLES;
        hold_active <= 1'b1;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      hold_active <= 1'b0;
      out_ready   <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
      if (taken % 40 == 0) pace = pace_t'($urandom_range(0, 2));
    end
  end

  initial begin : stimulus
    setting_t plan[SETTING_COUNT];
    plan[0] = '{4096, 4096, 2048, 255};
    plan[1] = '{8191, 8191, 8191, 0};
    plan[2] = '{0, 128, 12, 200};
    plan[3] = '{256, 0, 12, 77};
    plan[4] = '{64, 48, 0, 128};
    plan[5] = '{1, 1, 4095, 255};
    plan[6] = '{4097, 30, 15, 1};
    plan[7] = '{24, 24, 12, 254};
    for (int k = 8; k < SETTING_COUNT; k++) begin
      plan[k].width  = $urandom_range(1, 320);
      plan[k].height = $urandom_range(1, 320);
      plan[k].radius = $urandom_range(0, 170);
      plan[k].alpha  = ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(0, 255);
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: a 256 by 128 frame with radius 12 and full alpha.
    send_pixel(0, 0, 255, 255, 255);
    send_pixel(255, 0, 255, 0, 128);
    send_pixel(0, 127, 0, 255, 1);
    send_pixel(255, 127, 128, 128, 128);
    send_pixel(128, 64, 255, 255, 255);
    send_pixel(11, 11, 200, 100, 50);
    send_pixel(12, 12, 17, 34, 51);
    send_pixel(3, 3, 255, 255, 255);
    send_pixel(4, 2, 99, 180, 255);
    send_pixel(243, 3, 255, 1, 254);
    send_pixel(0, 64, 77, 88, 99);
    send_pixel(128, 0, 255, 255, 0);
    send_pixel(4095, 4095, 255, 255, 255);
    send_pixel(4095, 0, 255, 128, 64);
    send_pixel(0, 4095, 64, 128, 255);
    send_pixel(2730, 1365, 170, 85, 15);
    in_valid <= 1'b0;
    drain();

    for (int k = 0; k < SETTING_COUNT; k++) begin
      if (k == 3 || k == 10) hold_req <= k;
      apply_setting(plan[k]);
      for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
        send_pixel(pick_coord(span_w, eff_radius), pick_coord(span_h, eff_radius),
                   pick_byte(), pick_byte(), pick_byte());
      end
      in_valid <= 1'b0;
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Checked %0d result beats from %0d pixels over %0d register settings,",
             results_checked, pixels_sent, settings_applied);
    $display("oversized, empty and zero radius frames among them; input held off %0d cycles.",
             backpressure_cycles);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/rcap_pkg.sv
rtl/rcap_isqrt_pipe.sv
rtl/rounded_corner_alpha_premultiply_top.sv
verif/rcap_bgra_checker.sv
verif/tb.sv
